// File: rtl/sed_pkg.sv
// shared types and constants for the string escape decoder
// no dependencies; used by every module of the block

package sed_pkg;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_N         = 8'h6E;
   localparam logic [7:0] CHAR_Z         = 8'h7A;
   localparam logic [7:0] CHAR_DOLLAR    = 8'h24;
   localparam logic [7:0] CHAR_ZERO      = 8'h30;
   localparam logic [7:0] CHAR_NINE      = 8'h39;
   localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
   localparam logic [7:0] CTRL_LIMIT     = 8'd32;
   localparam logic [7:0] SEP_RESET      = 8'd34;

   // one queue entry: the one or two results caused by one input byte
   typedef struct packed {
      logic       second_vld;
      logic [7:0] byte0;
      logic       end0;
      logic [7:0] byte1;
      logic       end1;
   } sed_entry_type;

   // hex digit check: {valid, value}
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] res;
      res = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         res = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         res = {1'b1, b[3:0] + 4'd9};
      end
      return res;
   endfunction

endpackage

// File: rtl/sed_front.sv
// front end: separator register, escape state machine, builds queue entries
// depends on sed_pkg

module sed_front import sed_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_valid,
   input  logic [7:0]    csr_wdata,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] in_byte
   input  logic          q_full,
   output logic          q_push,
   output sed_entry_type q_data
);

   typedef enum logic [2:0] {
      MODE_PLAIN = 3'd0,
      MODE_ESC   = 3'd1,
      MODE_SKIP  = 3'd2,
      MODE_HEX   = 3'd3,
      MODE_DEC   = 3'd4
   } mode_type;

   mode_type   mode_ff, mode_in;
   logic [9:0] pending_ff, pending_in;
   logic [1:0] count_ff, count_in;
   logic [7:0] sep_ff;

   logic [7:0] b;
   logic       accept;
   logic       has0;
   logic [4:0] hex_chk;
   logic       is_dec;
   logic [9:0] hex_acc, dec_acc;
   logic       pb_esc, pb_end;
   logic [7:0] pb_byte;

   assign b          = req_tdata;
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept && has0;

   assign hex_chk = hex_digit(b);
   assign is_dec  = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
   assign hex_acc = {pending_ff[5:0], 4'b0000} + {6'd0, hex_chk[3:0]};
   assign dec_acc = (pending_ff << 3) + (pending_ff << 1) + {6'd0, b[3:0]};

   // byte handled as plain text
   assign pb_esc  = (b == CHAR_BACKSLASH);
   assign pb_end  = (b == sep_ff);
   assign pb_byte = pb_end ? 8'd0 : b;

   always_comb begin
      mode_in    = mode_ff;
      pending_in = pending_ff;
      count_in   = count_ff;
      has0       = 1'b0;
      q_data     = '0;
      case (mode_ff)
         MODE_ESC: begin
            mode_in    = MODE_PLAIN;
            pending_in = 10'd0;
            count_in   = 2'd0;
            if (b < CTRL_LIMIT) begin
               mode_in = MODE_SKIP;
            end else if (b == CHAR_N) begin
               has0         = 1'b1;
               q_data.byte0 = CHAR_NEWLINE;
            end else if (b == CHAR_Z) begin
               has0 = 1'b1;
            end else if (b == CHAR_DOLLAR) begin
               mode_in = MODE_HEX;
            end else if (is_dec) begin
               mode_in    = MODE_DEC;
               pending_in = {6'd0, b[3:0]};
               count_in   = 2'd1;
            end else begin
               has0         = 1'b1;
               q_data.byte0 = b;
            end
         end
         MODE_SKIP: begin
            if (b >= CTRL_LIMIT) begin
               pending_in   = 10'd0;
               count_in     = 2'd0;
               mode_in      = pb_esc ? MODE_ESC : MODE_PLAIN;
               has0         = !pb_esc;
               q_data.byte0 = pb_byte;
               q_data.end0  = pb_end;
            end
         end
         MODE_HEX: begin
            if (hex_chk[4]) begin
               if (count_ff >= 2'd1) begin
                  has0         = 1'b1;
                  q_data.byte0 = hex_acc[7:0];
                  mode_in      = MODE_PLAIN;
                  pending_in   = 10'd0;
                  count_in     = 2'd0;
               end else begin
                  pending_in = hex_acc;
                  count_in   = 2'd1;
               end
            end else begin
               // number first, then the byte as plain text
               has0              = 1'b1;
               q_data.byte0      = pending_ff[7:0];
               q_data.second_vld = !pb_esc;
               q_data.byte1      = pb_byte;
               q_data.end1       = pb_end;
               mode_in           = pb_esc ? MODE_ESC : MODE_PLAIN;
               pending_in        = 10'd0;
               count_in          = 2'd0;
            end
         end
         MODE_DEC: begin
            if (is_dec) begin
               if (count_ff >= 2'd2) begin
                  has0         = 1'b1;
                  q_data.byte0 = dec_acc[7:0];
                  mode_in      = MODE_PLAIN;
                  pending_in   = 10'd0;
                  count_in     = 2'd0;
               end else begin
                  pending_in = dec_acc;
                  count_in   = 2'd2;
               end
            end else begin
               has0              = 1'b1;
               q_data.byte0      = pending_ff[7:0];
               q_data.second_vld = !pb_esc;
               q_data.byte1      = pb_byte;
               q_data.end1       = pb_end;
               mode_in           = pb_esc ? MODE_ESC : MODE_PLAIN;
               pending_in        = 10'd0;
               count_in          = 2'd0;
            end
         end
         default: begin
            pending_in   = 10'd0;
            count_in     = 2'd0;
            mode_in      = pb_esc ? MODE_ESC : MODE_PLAIN;
            has0         = !pb_esc;
            q_data.byte0 = pb_byte;
            q_data.end0  = pb_end;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_PLAIN;
         pending_ff <= 10'd0;
         count_ff   <= 2'd0;
         sep_ff     <= SEP_RESET;
      end else begin
         if (accept) begin
            mode_ff    <= mode_in;
            pending_ff <= pending_in;
            count_ff   <= count_in;
         end
         if (csr_valid) begin
            sep_ff <= csr_wdata;
         end
      end
   end

endmodule

// File: rtl/sed_queue.sv
// short entry queue between the front end and the output stage
// depends on sed_pkg

module sed_queue import sed_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  sed_entry_type push_data,
   output logic          full,
   input  logic          pop,
   output logic          head_vld,
   output sed_entry_type head_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   sed_entry_type    mem [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = (cnt_ff == FULL_CNT);
   assign head_vld  = (cnt_ff != '0);
   assign head_data = mem[rd_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && head_vld;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LAST_IDX) ? '0 : wr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == LAST_IDX) ? '0 : rd_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/sed_back.sv
// output stage: splits queue entries into single results, holds the output register
// depends on sed_pkg

module sed_back import sed_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          head_vld,
   input  sed_entry_type head_data,
   output logic          pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [7:0]    rsp_tdata,   // [7:0] out_byte
   output logic          rsp_tuser,   // [0] string_end
   output logic          rsp_tlast    // last_of_run
);

   logic       out_vld_ff;
   logic [7:0] out_byte_ff;
   logic       out_end_ff;
   logic       out_last_ff;
   logic       sec_vld_ff;
   logic [7:0] sec_byte_ff;
   logic       sec_end_ff;
   logic       load;

   assign load = !out_vld_ff || rsp_tready;
   assign pop  = load && !sec_vld_ff && head_vld;

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = out_end_ff;
   assign rsp_tlast  = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         sec_vld_ff <= 1'b0;
      end else if (load) begin
         if (sec_vld_ff) begin
            out_vld_ff <= 1'b1;
            sec_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= head_vld;
            sec_vld_ff <= head_vld && head_data.second_vld;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         if (sec_vld_ff) begin
            out_byte_ff <= sec_byte_ff;
            out_end_ff  <= sec_end_ff;
            out_last_ff <= 1'b1;
         end else begin
            out_byte_ff <= head_data.byte0;
            out_end_ff  <= head_data.end0;
            out_last_ff <= !head_data.second_vld;
            sec_byte_ff <= head_data.byte1;
            sec_end_ff  <= head_data.end1;
         end
      end
   end

`ifndef SYNTH
   // a held second result only exists behind the first one on the output
   a_sec_behind_out: assert property (@(posedge clock) disable iff (reset)
      sec_vld_ff |-> out_vld_ff)
      else $error("second result pending with empty output register");

   // the first of a pair is never flagged last
   a_pair_not_last: assert property (@(posedge clock) disable iff (reset)
      sec_vld_ff |-> !rsp_tlast)
      else $error("first of two results marked last");

   // an end marker carries a zero byte
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata == 8'd0))
      else $error("end marker with nonzero byte");

   // no queue pop while the second half of an entry is outstanding
   a_no_pop_sec: assert property (@(posedge clock) disable iff (reset)
      sec_vld_ff |-> !pop)
      else $error("queue popped while second result pending");
`endif

endmodule

// File: rtl/string_escape_decoder.sv
// string literal body decoder, top level
// depends on sed_pkg, sed_front, sed_queue, sed_back
//
// usage:
//   req_*  : raw body bytes, one per transaction, req_tdata[7:0] = in_byte
//   rsp_*  : decoded results, rsp_tdata[7:0] = out_byte, rsp_tuser = string_end,
//            rsp_tlast = last result caused by one input byte
//   csr_*  : write of the separator byte; always ready, write only while idle
// an input byte gives zero, one or two results. a byte is accepted every cycle
// while the entry queue has room; the first result of a byte passes the queue and
// then the output register before it shows on rsp. a byte giving two results holds
// the output register for both in turn, so sustained output is one result per cycle
// while rsp_tready is high; the queue (QUEUE_DEPTH entries) absorbs the extra.
// when rsp_tready is low the output register holds its result, the queue fills
// and req_tready drops once it is full.
// reset empties the queue and output, returns to plain mode and sets the
// separator to the double quote.

module string_escape_decoder import sed_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_wdata,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] string_end
   output logic       rsp_tlast    // last_of_run
);

   sed_entry_type push_data, head_data;
   logic          push, full, pop, head_vld;

   assign csr_ready = 1'b1;

   sed_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (full),
      .q_push     (push),
      .q_data     (push_data)
   );

   sed_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .head_vld  (head_vld),
      .head_data (head_data)
   );

   sed_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_vld   (head_vld),
      .head_data  (head_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for the string escape decoder
// depends on sed_pkg and the string_escape_decoder top level

module tb_top;
   import sed_pkg::*;

   // bound for the slowest run: roughly 1.8k bytes, each with an input gap and two sink stalls, plus holds
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 12;
   localparam int MAX_WAIT      = 18;
   localparam int PHASE_ITEMS   = 280;
   localparam int HOLD_CYCLES   = 300;

   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_F = 8'h46;

   typedef enum logic [2:0] {
      MODE_PLAIN     = 3'd0,
      MODE_ESCAPE    = 3'd1,
      MODE_SKIP_CTRL = 3'd2,
      MODE_HEX       = 3'd3,
      MODE_DEC       = 3'd4
   } decode_mode_type;

   typedef struct packed {
      logic [7:0] data;
      logic       term;
      logic       is_last;
   } decoded_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       csr_valid  = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_wdata  = 8'd0;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'd0;   // [7:0] in_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tuser;           // [0] string_end
   logic       rsp_tlast;

   // decoder image kept by the testbench
   decode_mode_type model_mode   = MODE_PLAIN;
   logic [9:0]      model_value  = 10'd0;
   logic [1:0]      model_digits = 2'd0;
   logic [7:0]      model_sep    = SEP_RESET;

   decoded_type expected_q[$];
   decoded_type step_q[$];
   logic [7:0]  byte_plan[$];

   int  fail_count    = 0;
   int  bytes_sent    = 0;
   int  results_seen  = 0;
   int  settings_used = 0;
   int  cycle_count   = 0;
   int  sink_hold     = 0;
   bit  steady        = 1'b0;

   string_escape_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, expected_q.size());
         $display("tb_top failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- decode image

   function automatic void note_result(input logic [7:0] d, input logic t);
      decoded_type r;
      r.data    = d;
      r.term    = t;
      r.is_last = 1'b0;
      step_q.push_back(r);
   endfunction

   function automatic int hex_of(input logic [7:0] b);
      if (b >= CHAR_ZERO && b <= CHAR_NINE) return int'(b - CHAR_ZERO);
      if (b >= CHAR_LOWER_A && b <= CHAR_LOWER_F) return int'(b - CHAR_LOWER_A) + 10;
      if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F) return int'(b - CHAR_UPPER_A) + 10;
      return -1;
   endfunction

   function automatic void decode_plain(input logic [7:0] b);
      model_mode   = MODE_PLAIN;
      model_value  = 10'd0;
      model_digits = 2'd0;
      // backslash is checked ahead of the separator
      if (b == CHAR_BACKSLASH) model_mode = MODE_ESCAPE;
      else if (b == model_sep) note_result(8'd0, 1'b1);
      else note_result(b, 1'b0);
   endfunction

   function automatic void predict_byte(input logic [7:0] b);
      int          h;
      decoded_type r;
      step_q.delete();
      case (model_mode)
         MODE_ESCAPE: begin
            model_mode   = MODE_PLAIN;
            model_value  = 10'd0;
            model_digits = 2'd0;
            if (b < CTRL_LIMIT) begin
               model_mode = MODE_SKIP_CTRL;
            end else if (b == CHAR_N) begin
               note_result(CHAR_NEWLINE, 1'b0);
            end else if (b == CHAR_Z) begin
               note_result(8'd0, 1'b0);
            end else if (b == CHAR_DOLLAR) begin
               model_mode = MODE_HEX;
            end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
               model_mode   = MODE_DEC;
               model_value  = 10'(b - CHAR_ZERO);
               model_digits = 2'd1;
            end else begin
               note_result(b, 1'b0);
            end
         end
         MODE_SKIP_CTRL: begin
            if (b >= CTRL_LIMIT) decode_plain(b);
         end
         MODE_HEX: begin
            h = hex_of(b);
            if (h >= 0) begin
               model_value = (model_value << 4) + 10'(h);
               if (model_digits >= 2'd1) begin
                  note_result(model_value[7:0], 1'b0);
                  model_mode   = MODE_PLAIN;
                  model_value  = 10'd0;
                  model_digits = 2'd0;
               end else begin
                  model_digits = 2'd1;
               end
            end else begin
               note_result(model_value[7:0], 1'b0);
               decode_plain(b);
            end
         end
         MODE_DEC: begin
            if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
               model_value = 10'(int'(model_value) * 10 + int'(b - CHAR_ZERO));
               if (model_digits >= 2'd2) begin
                  note_result(model_value[7:0], 1'b0);
                  model_mode   = MODE_PLAIN;
                  model_value  = 10'd0;
                  model_digits = 2'd0;
               end else begin
                  model_digits = 2'd2;
               end
            end else begin
               note_result(model_value[7:0], 1'b0);
               decode_plain(b);
            end
         end
         default: decode_plain(b);
      endcase
      foreach (step_q[i]) begin
         r         = step_q[i];
         r.is_last = (i == step_q.size() - 1);
         expected_q.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------- handshakes

   function automatic int draw_wait();
      if (steady || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, MAX_WAIT);
   endfunction

   // called right after a rising edge; returns at the edge that took the byte
   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      predict_byte(b);
      bytes_sent++;
   endtask

   task automatic send_plan();
      foreach (byte_plan[i]) send_byte(byte_plan[i]);
      byte_plan.delete();
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      // a trailing byte with no result may still be in flight
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_separator(input logic [7:0] v);
      wait_idle();
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      model_sep = v;
      settings_used++;
   endtask

   initial begin : result_sink
      int pause;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (sink_hold > 0) begin
            pause     = sink_hold;
            sink_hold = 0;
         end else begin
            pause = draw_wait();
         end
         if (pause > 0) begin
            rsp_tready <= 1'b0;
            repeat (pause) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   always @(posedge clock) begin : result_check
      decoded_type got;
      decoded_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.data    = rsp_tdata;
         got.term    = rsp_tuser;
         got.is_last = rsp_tlast;
         results_seen++;
         if (expected_q.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected result: expected none, actual data %h end %b last %b",
                     $time, got.data, got.term, got.is_last);
         end else begin
            want = expected_q.pop_front();
            if (got.data !== want.data) begin
               fail_count++;
               $display("%0t: out_byte mismatch: expected %h, actual %h",
                        $time, want.data, got.data);
            end
            if (got.term !== want.term) begin
               fail_count++;
               $display("%0t: string_end mismatch: expected %b, actual %b",
                        $time, want.term, got.term);
            end
            if (got.is_last !== want.is_last) begin
               fail_count++;
               $display("%0t: last_of_run mismatch: expected %b, actual %b",
                        $time, want.is_last, got.is_last);
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic logic [7:0] random_hex_digit();
      int v;
      v = $urandom_range(0, 15);
      if (v < 10) return CHAR_ZERO + 8'(v);
      if ($urandom_range(0, 1) == 1) return CHAR_LOWER_A + 8'(v - 10);
      return CHAR_UPPER_A + 8'(v - 10);
   endfunction

   task automatic add_random_chunk();
      int kind;
      int n;
      kind = $urandom_range(0, 11);
      case (kind)
         0, 1: byte_plan.push_back(8'($urandom_range(0, 255)));
         2: byte_plan.push_back(model_sep);
         3: byte_plan = {byte_plan, CHAR_BACKSLASH, CHAR_N};
         4: byte_plan = {byte_plan, CHAR_BACKSLASH, CHAR_Z};
         5, 6: begin
            byte_plan = {byte_plan, CHAR_BACKSLASH, CHAR_DOLLAR};
            n = $urandom_range(0, 2);
            repeat (n) byte_plan.push_back(random_hex_digit());
            if (n < 2) byte_plan.push_back(8'($urandom_range(32, 255)));
         end
         7, 8: begin
            byte_plan.push_back(CHAR_BACKSLASH);
            n = $urandom_range(1, 3);
            repeat (n) byte_plan.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
            if (n < 3) byte_plan.push_back(8'($urandom_range(0, 255)));
         end
         9: begin
            byte_plan.push_back(CHAR_BACKSLASH);
            n = $urandom_range(1, 4);
            repeat (n) byte_plan.push_back(8'($urandom_range(0, 31)));
            byte_plan.push_back(8'($urandom_range(0, 255)));
         end
         10: byte_plan = {byte_plan, CHAR_BACKSLASH, 8'($urandom_range(0, 255))};
         default: begin
            n = $urandom_range(1, 6);
            repeat (n) byte_plan.push_back(8'($urandom_range(32, 126)));
         end
      endcase
   endtask

   task automatic test_directed();
      // plain bytes, end of string, each escape, numbers cut short, control skip
      byte_plan = '{8'h61, 8'h00, 8'hFF, SEP_RESET,
                    CHAR_BACKSLASH, CHAR_N, CHAR_BACKSLASH, CHAR_Z,
                    CHAR_BACKSLASH, CHAR_DOLLAR, 8'h34, 8'h31,
                    CHAR_BACKSLASH, CHAR_DOLLAR, 8'h67,
                    CHAR_BACKSLASH, CHAR_DOLLAR, 8'h46, SEP_RESET,
                    CHAR_BACKSLASH, 8'h32, 8'h35, 8'h35,
                    CHAR_BACKSLASH, 8'h31, 8'h78,
                    CHAR_BACKSLASH, SEP_RESET,
                    CHAR_BACKSLASH, 8'h01, 8'h1F, 8'h41};
      send_plan();
   endtask

   task automatic test_separator_cases();
      // backslash as separator, number overflow past 8 bits
      write_separator(CHAR_BACKSLASH);
      byte_plan = '{CHAR_BACKSLASH, 8'h39, 8'h39, 8'h39,
                    CHAR_BACKSLASH, 8'h37, CHAR_BACKSLASH, CHAR_N,
                    CHAR_BACKSLASH, 8'h01, CHAR_BACKSLASH, CHAR_Z};
      send_plan();
      // control separator is dropped while skipping
      write_separator(8'h05);
      byte_plan = '{CHAR_BACKSLASH, 8'h02, 8'h05, 8'h1E, 8'h41, 8'h05,
                    CHAR_BACKSLASH, 8'h05, 8'h20};
      send_plan();
      write_separator(8'h00);
      byte_plan = '{8'h00, CHAR_BACKSLASH, CHAR_Z, CHAR_BACKSLASH, 8'h00, 8'h00, 8'h7E};
      send_plan();
      write_separator(8'hFF);
      byte_plan = '{8'hFF, CHAR_BACKSLASH, 8'hFF, CHAR_BACKSLASH, CHAR_DOLLAR, 8'hFF};
      send_plan();
   endtask

   task automatic test_random_traffic();
      logic [7:0] seps[6];
      int         start;
      seps = '{SEP_RESET, 8'h00, 8'hFF, CHAR_BACKSLASH,
               8'($urandom_range(0, 255)), 8'($urandom_range(0, 31))};
      foreach (seps[p]) begin
         write_separator(seps[p]);
         // one phase with no idling on either side
         steady = (p == 2);
         start  = bytes_sent;
         while (bytes_sent - start < PHASE_ITEMS) begin
            add_random_chunk();
            send_plan();
         end
         steady = 1'b0;
      end
   endtask

   task automatic test_input_stall();
      write_separator(SEP_RESET);
      steady    = 1'b1;
      sink_hold = HOLD_CYCLES;
      repeat (50) byte_plan.push_back(8'($urandom_range(32, 126)));
      byte_plan = {byte_plan, CHAR_BACKSLASH, 8'h31, 8'h78, CHAR_BACKSLASH, 8'h39, 8'h39};
      send_plan();
      steady = 1'b0;
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_separator_cases();
      test_random_traffic();
      test_input_stall();
      wait_idle();
      $display("sent %0d body bytes under %0d separator writes, checked %0d decoded results",
               bytes_sent, settings_used, results_seen);
      if (fail_count == 0 && expected_q.size() == 0) begin
         $display("tb_top passed");
      end else begin
         $display("tb_top failed");
      end
      $finish;
   end

endmodule
